>>> hdl/zx7e_pkg.sv
// ----------------------------------------------------------------------------
// zx7e_pkg: shared types, constants and microcode for the zx7 token encoder
// Holds the channel codes, the byte queue geometry, the control word format of
// the sequencer and its program table.
// ----------------------------------------------------------------------------
package zx7e_pkg;

  // Byte queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

  // Results per item are capped
  localparam int MAX_RESULTS = 24;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  // Token limits
  localparam logic [16:0] MIN_LENGTH   = 17'd2;
  localparam logic [16:0] MAX_LENGTH   = 17'd65536;
  localparam logic [11:0] MAX_OFFSET   = 12'd2176;
  localparam logic [11:0] SHORT_OFFSET = 12'd128;

  // Stop code: one, sixteen zeros, one
  localparam int          STOP_BITS = 18;
  localparam logic [17:0] STOP_CODE = 18'h20001;

  // Bit word sizes
  localparam logic [4:0] WORD8  = 5'd8;
  localparam logic [4:0] WORD16 = 5'd16;

  // Input actions
  localparam logic [1:0] ACT_RAW     = 2'd0;
  localparam logic [1:0] ACT_LITERAL = 2'd1;
  localparam logic [1:0] ACT_MATCH   = 2'd2;
  localparam logic [1:0] ACT_FINISH  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WORD_MODE  = 2'd0;
  localparam logic [1:0] CFG_BIG_ENDIAN = 2'd1;
  localparam logic [1:0] CFG_FULL_BITS  = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Microcode operations
  typedef enum logic [3:0] {
    OP_EMIT_IN    = 4'd0,
    OP_CHECK      = 4'd1,
    OP_PUSH       = 4'd2,
    OP_QADD_BYTE  = 4'd3,
    OP_QADD_OFF   = 4'd4,
    OP_LOAD_VAL   = 4'd5,
    OP_LOAD_OFFHI = 4'd6,
    OP_PAD        = 4'd7,
    OP_CLEAR      = 4'd8,
    OP_END        = 4'd9
  } op_t;

  // Jump conditions, evaluated when a step completes
  typedef enum logic [1:0] {
    JC_NONE    = 2'd0,
    JC_ALWAYS  = 2'd1,
    JC_SHORT   = 2'd2,
    JC_INVALID = 2'd3
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Program entry points
  localparam pc_t PC_RAW   = 4'd0;
  localparam pc_t PC_LIT   = 4'd1;
  localparam pc_t PC_MATCH = 4'd3;
  localparam pc_t PC_FIN   = 4'd10;
  localparam pc_t PC_END   = 4'd13;

  // Sequencer to output unit
  typedef struct packed {
    logic       flush;       // start a word flush followed by a queue drain
    logic       drain;       // start a queue drain only
    logic       word16;
    logic       big_endian;
    logic       qadd;
    logic [7:0] qbyte;
    logic       put;         // emit one result from the sequencer
    logic [7:0] put_byte;
    status_t    put_status;
    logic       put_err;     // error results bypass the result cap
    logic       close;       // finish the item: error if any, mark last
    logic       clear;       // empty the queue at end of stream
  } emit_ctl_t;

  // Output unit to sequencer
  typedef struct packed {
    logic busy;
    logic put_ok;
    logic close_done;
  } emit_sts_t;

  // Number of significant bits of a 16-bit value
  function automatic logic [4:0] bit_len(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  // Program entry by action
  function automatic pc_t entry_pc(input logic [1:0] action);
    pc_t pc;
    unique case (action)
      ACT_RAW:     pc = PC_RAW;
      ACT_LITERAL: pc = PC_LIT;
      ACT_MATCH:   pc = PC_MATCH;
      default:     pc = PC_FIN;
    endcase
    return pc;
  endfunction

  // Control store
  function automatic uword_t micro_rom(input pc_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_EMIT_IN,    JC_ALWAYS,  PC_END};
      4'd1:    w = '{OP_PUSH,       JC_NONE,    PC_END};
      4'd2:    w = '{OP_QADD_BYTE,  JC_ALWAYS,  PC_END};
      4'd3:    w = '{OP_CHECK,      JC_INVALID, PC_END};
      4'd4:    w = '{OP_PUSH,       JC_NONE,    PC_END};
      4'd5:    w = '{OP_LOAD_VAL,   JC_NONE,    PC_END};
      4'd6:    w = '{OP_PUSH,       JC_NONE,    PC_END};
      4'd7:    w = '{OP_QADD_OFF,   JC_SHORT,   PC_END};
      4'd8:    w = '{OP_LOAD_OFFHI, JC_NONE,    PC_END};
      4'd9:    w = '{OP_PUSH,       JC_ALWAYS,  PC_END};
      4'd10:   w = '{OP_PUSH,       JC_NONE,    PC_END};
      4'd11:   w = '{OP_PAD,        JC_NONE,    PC_END};
      4'd12:   w = '{OP_CLEAR,      JC_NONE,    PC_END};
      default: w = '{OP_END,        JC_NONE,    PC_END};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/zx7e_in_if.sv
// ----------------------------------------------------------------------------
// zx7e_in_if: token input channel
// Valid/ready channel carrying one LZ token per item.
// ----------------------------------------------------------------------------
interface zx7e_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  byte_value;
  logic [16:0] match_length;
  logic [11:0] match_offset;

  modport source (output valid, action, byte_value, match_length, match_offset,
                  input ready);
  modport sink   (input valid, action, byte_value, match_length, match_offset,
                  output ready);
endinterface

>>> hdl/zx7e_out_if.sv
// ----------------------------------------------------------------------------
// zx7e_out_if: result channel
// Valid/ready channel carrying one stream byte or error result per item.
// ----------------------------------------------------------------------------
interface zx7e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input valid, out_byte, status, last, output ready);
endinterface

>>> hdl/zx7e_emit.sv
// ----------------------------------------------------------------------------
// zx7e_emit: byte queue, word flush and result output stage
// Holds the offset/literal byte queue, runs word flushes and queue drains,
// caps results per item and keeps one result pending so the final one of an
// item can be marked last.
// ----------------------------------------------------------------------------
module zx7e_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  zx7e_pkg::emit_ctl_t ctl,
  input  logic [15:0]         acc,
  output zx7e_pkg::emit_sts_t sts,
  zx7e_out_if.source          out_ch
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_BYTE0 = 4'b0010,
    F_BYTE1 = 4'b0100,
    F_DRAIN = 4'b1000
  } fstate_t;

  localparam int QW = zx7e_pkg::QIDX_W;
  localparam int CW = zx7e_pkg::RCNT_W;
  localparam logic [QW-1:0] QLAST = QW'(zx7e_pkg::QUEUE_DEPTH - 1);

  fstate_t f_state_r, f_state_nxt;
  logic    w16_r, be_r;

  logic [7:0]    mem [zx7e_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_inc, rd_inc;
  logic [7:0]    q_rd_data_r;
  logic          q_full, q_wr;

  logic              pend_v_r, pend_v_nxt;
  logic [7:0]        pend_byte_r;
  zx7e_pkg::status_t pend_status_r;

  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_byte_r;
  zx7e_pkg::status_t out_status_r;
  logic              out_last_r;

  logic [CW-1:0] res_cnt_r, res_cnt_nxt, cap_lim;
  logic          ovf_r, ovf_nxt;

  logic              gen_v, gen_err;
  logic [7:0]        gen_byte;
  zx7e_pkg::status_t gen_status;
  logic              drop, out_free, room, gen_fire, keep, fin, pend_to_out;

  // Queue index arithmetic with wrap
  assign wr_inc = (wr_r == QLAST) ? '0 : wr_r + QW'(1);
  assign rd_inc = (rd_r == QLAST) ? '0 : rd_r + QW'(1);
  assign q_full = (wr_inc == rd_r);
  assign q_wr   = ctl.qadd && !q_full;

  // Pick the result offered this cycle
  always_comb begin
    gen_v      = 1'b0;
    gen_err    = 1'b0;
    gen_byte   = 8'd0;
    gen_status = zx7e_pkg::ST_DATA;
    unique case (f_state_r)
      F_BYTE0: begin
        gen_v    = 1'b1;
        gen_byte = (w16_r && be_r) ? acc[15:8] : acc[7:0];
      end
      F_BYTE1: begin
        gen_v    = 1'b1;
        gen_byte = be_r ? acc[7:0] : acc[15:8];
      end
      F_DRAIN: begin
        gen_v    = (rd_r != wr_r);
        gen_byte = q_rd_data_r;
      end
      F_IDLE: begin
        if (ctl.put) begin
          gen_v      = 1'b1;
          gen_byte   = ctl.put_byte;
          gen_status = ctl.put_status;
          gen_err    = ctl.put_err;
        end else if (ctl.close && ovf_r) begin
          gen_v      = 1'b1;
          gen_status = zx7e_pkg::ST_OVERFLOW;
          gen_err    = 1'b1;
        end
      end
      default: gen_v = 1'b0;
    endcase
  end

  // Drop data results beyond the cap; one slot stays free for an overflow error
  assign cap_lim  = ovf_r ? CW'(zx7e_pkg::MAX_RESULTS - 1) : CW'(zx7e_pkg::MAX_RESULTS);
  assign drop     = !gen_err && (res_cnt_r >= cap_lim);
  assign out_free = !out_v_r || out_ch.ready;
  assign room     = !pend_v_r || out_free;
  assign gen_fire = gen_v && (drop || room);
  assign keep     = gen_fire && !drop;
  assign fin      = (f_state_r == F_IDLE) && ctl.close && !ovf_r && room;
  assign pend_to_out = pend_v_r && (keep || fin);

  // Flush sequencing and queue indexes
  always_comb begin
    f_state_nxt = f_state_r;
    rd_nxt      = rd_r;
    wr_nxt      = q_wr ? wr_inc : wr_r;
    unique case (f_state_r)
      F_IDLE: begin
        if (ctl.flush)      f_state_nxt = F_BYTE0;
        else if (ctl.drain) f_state_nxt = F_DRAIN;
      end
      F_BYTE0: if (gen_fire) f_state_nxt = w16_r ? F_BYTE1 : F_DRAIN;
      F_BYTE1: if (gen_fire) f_state_nxt = F_DRAIN;
      F_DRAIN: begin
        if (rd_r == wr_r) f_state_nxt = F_IDLE;
        if (gen_fire)     rd_nxt = rd_inc;
      end
      default: f_state_nxt = F_IDLE;
    endcase
    if (ctl.clear) begin
      rd_nxt = '0;
      wr_nxt = '0;
    end
  end

  // Pending, output, count and overflow next values
  always_comb begin
    pend_v_nxt  = pend_v_r;
    out_v_nxt   = out_v_r && !out_ch.ready;
    res_cnt_nxt = res_cnt_r;
    ovf_nxt     = ovf_r || (ctl.qadd && q_full);
    if (pend_to_out) out_v_nxt = 1'b1;
    if (keep) begin
      pend_v_nxt  = 1'b1;
      res_cnt_nxt = res_cnt_r + CW'(1);
    end
    if (gen_fire && gen_status == zx7e_pkg::ST_OVERFLOW) ovf_nxt = 1'b0;
    if (fin) begin
      pend_v_nxt  = 1'b0;
      res_cnt_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_state_r <= F_IDLE;
      wr_r      <= '0;
      rd_r      <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      res_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      f_state_r <= f_state_nxt;
      wr_r      <= wr_nxt;
      rd_r      <= rd_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      res_cnt_r <= res_cnt_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (f_state_r == F_IDLE && ctl.flush) begin
      w16_r <= ctl.word16;
      be_r  <= ctl.big_endian;
    end
    if (pend_to_out) begin
      out_byte_r   <= pend_byte_r;
      out_status_r <= pend_status_r;
      out_last_r   <= fin;
    end
    if (keep) begin
      pend_byte_r   <= gen_byte;
      pend_status_r <= gen_status;
    end
  end

  // Queue storage; read data always tracks the next read index
  always_ff @(posedge clk) begin
    if (q_wr) mem[wr_r] <= ctl.qbyte;
    q_rd_data_r <= mem[rd_nxt];
  end

  assign sts.busy       = (f_state_r != F_IDLE);
  assign sts.put_ok     = (f_state_r == F_IDLE) && ctl.put && gen_fire;
  assign sts.close_done = fin;

  assign out_ch.valid    = out_v_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

endmodule

>>> hdl/zx7_token_bitstream_encoder_core.sv
// ----------------------------------------------------------------------------
// zx7_token_bitstream_encoder_core: zx7-style LZ token to byte stream encoder
// A microcoded sequencer packs flag bits and Elias-gamma codes into bit words
// and hands word flushes, queued bytes and results to the output unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one token per item (raw byte, literal, match or finish).
//   out_ch gives the stream bytes, or one error result; the final result of
//          a token carries last. A literal that fills no word gives none.
//   cfg_we/cfg_index/cfg_data write word_mode, big_endian and full_bits;
//   write them only while the block is idle.
// Flow: a token is accepted only when the sequencer is idle, so the next
//   token waits until the program of the last one ends. The program runs
//   its code bit shifts, queue adds, loads and close step in order, and
//   holds while the output unit flushes, drains or cannot take a result.
//   A word flush emits the word bytes and then drains the queued bytes; a
//   full word is flushed ahead of the next bit.
// Reset: synchronous, active low; clears the bit word, the queue indexes and
//   the registers. When out_ch stalls, results wait in the output and pending
//   registers and the sequencer holds until room frees up.
// ----------------------------------------------------------------------------
module zx7_token_bitstream_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  zx7e_in_if.sink    in_ch,
  zx7e_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [0:0] cfg_data
);

  // Configuration
  logic word_mode_r, big_endian_r, full_bits_r;

  // Sequencer
  logic             busy_r, busy_nxt;
  zx7e_pkg::pc_t    upc_r, upc_nxt;
  zx7e_pkg::uword_t uw;
  logic             exec, step_done, take_jump, in_fire;

  // Bit datapath
  logic [15:0] acc_r, acc_nxt;
  logic [4:0]  fill_r, fill_nxt, fill_inc, size, pad_amt;
  logic [17:0] sh_r, sh_nxt;
  logic [4:0]  cnt_r, cnt_nxt, bit_idx;
  logic        fill_full;

  // Token fields
  logic [7:0]  byte_r, qoff_r;
  logic [15:0] v_r;
  logic [4:0]  nb_r;
  logic [3:0]  offhi_r;
  logic        inv_r, short_r;

  // Token decode at acceptance
  logic [16:0] len_m1;
  logic [4:0]  nb_in;
  logic [11:0] off_t;
  logic        inv_in, short_in;

  zx7e_pkg::emit_ctl_t ctl;
  zx7e_pkg::emit_sts_t em_sts;

  assign in_fire      = in_ch.valid && !busy_r;
  assign in_ch.ready  = !busy_r;

  assign len_m1   = in_ch.match_length - 17'd1;
  assign nb_in    = zx7e_pkg::bit_len(len_m1[15:0]);
  assign off_t    = in_ch.match_offset - (zx7e_pkg::SHORT_OFFSET + 12'd1);
  assign short_in = (in_ch.match_offset <= zx7e_pkg::SHORT_OFFSET);
  assign inv_in   = (in_ch.match_length < zx7e_pkg::MIN_LENGTH) ||
                    (in_ch.match_length > zx7e_pkg::MAX_LENGTH) ||
                    (in_ch.match_offset == 12'd0) ||
                    (in_ch.match_offset > zx7e_pkg::MAX_OFFSET);

  assign size      = word_mode_r ? zx7e_pkg::WORD16 : zx7e_pkg::WORD8;
  assign fill_full = (fill_r >= size);
  assign fill_inc  = fill_r + 5'd1;
  assign bit_idx   = cnt_r - 5'd1;
  assign pad_amt   = fill_full ? 5'd0 : size - fill_r;

  assign uw   = zx7e_pkg::micro_rom(upc_r);
  assign exec = busy_r && !em_sts.busy;

  // Execute the current control word
  always_comb begin
    ctl            = '0;
    ctl.word16     = word_mode_r;
    ctl.big_endian = big_endian_r;
    ctl.put_status = zx7e_pkg::ST_DATA;
    acc_nxt        = acc_r;
    fill_nxt       = fill_r;
    sh_nxt         = sh_r;
    cnt_nxt        = cnt_r;
    step_done      = 1'b0;
    if (exec) begin
      unique case (uw.op)
        zx7e_pkg::OP_EMIT_IN: begin
          ctl.put      = 1'b1;
          ctl.put_byte = byte_r;
          step_done    = em_sts.put_ok;
        end
        zx7e_pkg::OP_CHECK: begin
          if (inv_r) begin
            ctl.put        = 1'b1;
            ctl.put_status = zx7e_pkg::ST_INVALID;
            ctl.put_err    = 1'b1;
            step_done      = em_sts.put_ok;
          end else begin
            step_done = 1'b1;
          end
        end
        zx7e_pkg::OP_PUSH: begin
          if (fill_full) begin
            // flush the full word before the next bit
            ctl.flush = 1'b1;
            fill_nxt  = 5'd0;
          end else begin
            acc_nxt = {acc_r[14:0], sh_r[bit_idx]};
            cnt_nxt = bit_idx;
            if (full_bits_r && fill_inc >= size) begin
              ctl.flush = 1'b1;
              fill_nxt  = 5'd0;
            end else begin
              fill_nxt = fill_inc;
            end
            step_done = (cnt_r == 5'd1);
          end
        end
        zx7e_pkg::OP_QADD_BYTE: begin
          ctl.qadd  = 1'b1;
          ctl.qbyte = byte_r;
          step_done = 1'b1;
        end
        zx7e_pkg::OP_QADD_OFF: begin
          ctl.qadd  = 1'b1;
          ctl.qbyte = qoff_r;
          step_done = 1'b1;
        end
        zx7e_pkg::OP_LOAD_VAL: begin
          sh_nxt    = {2'b00, v_r};
          cnt_nxt   = nb_r;
          step_done = 1'b1;
        end
        zx7e_pkg::OP_LOAD_OFFHI: begin
          sh_nxt    = {14'd0, offhi_r};
          cnt_nxt   = 5'd4;
          step_done = 1'b1;
        end
        zx7e_pkg::OP_PAD: begin
          // pad a partial word with zeros and flush it, else drain only
          if (fill_r != 5'd0) begin
            acc_nxt   = acc_r << pad_amt;
            ctl.flush = 1'b1;
            fill_nxt  = 5'd0;
          end else begin
            ctl.drain = 1'b1;
          end
          step_done = 1'b1;
        end
        zx7e_pkg::OP_CLEAR: begin
          acc_nxt   = 16'd0;
          fill_nxt  = 5'd0;
          ctl.clear = 1'b1;
          step_done = 1'b1;
        end
        zx7e_pkg::OP_END: begin
          ctl.close = 1'b1;
          step_done = em_sts.close_done;
        end
        default: step_done = 1'b1;
      endcase
    end
  end

  // Next step address
  always_comb begin
    unique case (uw.cond)
      zx7e_pkg::JC_ALWAYS:  take_jump = 1'b1;
      zx7e_pkg::JC_SHORT:   take_jump = short_r;
      zx7e_pkg::JC_INVALID: take_jump = inv_r;
      default:              take_jump = 1'b0;
    endcase
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (step_done) begin
      upc_nxt = take_jump ? uw.target : upc_r + zx7e_pkg::pc_t'(1);
      if (uw.op == zx7e_pkg::OP_END) busy_nxt = 1'b0;
    end
    if (in_fire) begin
      upc_nxt  = zx7e_pkg::entry_pc(in_ch.action);
      busy_nxt = 1'b1;
    end
  end

  // Control state and bit word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      upc_r        <= zx7e_pkg::PC_END;
      acc_r        <= 16'd0;
      fill_r       <= 5'd0;
      word_mode_r  <= 1'b0;
      big_endian_r <= 1'b0;
      full_bits_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
      if (cfg_we) begin
        case (cfg_index)
          zx7e_pkg::CFG_WORD_MODE:  word_mode_r  <= cfg_data[0];
          zx7e_pkg::CFG_BIG_ENDIAN: big_endian_r <= cfg_data[0];
          zx7e_pkg::CFG_FULL_BITS:  full_bits_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Token capture and bit source
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    if (in_fire) begin
      byte_r  <= in_ch.byte_value;
      v_r     <= len_m1[15:0];
      nb_r    <= nb_in;
      inv_r   <= inv_in;
      short_r <= short_in;
      qoff_r  <= short_in ? 8'(in_ch.match_offset - 12'd1) : {1'b1, off_t[6:0]};
      offhi_r <= off_t[10:7];
      case (in_ch.action)
        zx7e_pkg::ACT_LITERAL: begin
          sh_r  <= 18'd0;
          cnt_r <= 5'd1;
        end
        zx7e_pkg::ACT_MATCH: begin
          sh_r  <= 18'd1 << (nb_in - 5'd1);
          cnt_r <= nb_in;
        end
        zx7e_pkg::ACT_FINISH: begin
          sh_r  <= zx7e_pkg::STOP_CODE;
          cnt_r <= 5'(zx7e_pkg::STOP_BITS);
        end
        default: ;
      endcase
    end
  end

  zx7e_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .acc    (acc_r),
    .sts    (em_sts),
    .out_ch (out_ch)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the zx7 token bitstream encoder
// Feeds raw bytes, literals, matches and finish tokens through the input
// channel and models the bit word, the offset byte queue and the result cap.
// Every result is checked against the model. Both channels idle at random,
// and the register settings change between phases, mid-stream included.
// ----------------------------------------------------------------------------
module tb_top;

  // Bench limits
  localparam int          SETTLE_CYCLES = 150;
  localparam longint      TIMEOUT_NS    = 64'd12_000_000;
  localparam int          N_PHASES      = 7;
  localparam int          CHUNK_ITEMS   = 5;
  localparam int          Q_SLOTS       = 32;
  localparam int          RESULT_CAP    = 24;
  localparam int unsigned LEN_MAX       = 65536;
  localparam int unsigned OFF_MAX       = 2176;
  localparam int unsigned OFF_SHORT     = 128;
  localparam logic [31:0] STOP_PATTERN  = 32'h0002_0001;
  localparam int          STOP_LEN      = 18;

  // Register settings per phase, {word_mode, big_endian, full_bits}, phase 0 lowest
  localparam logic [3*N_PHASES-1:0] PHASE_CFG =
    {3'b000, 3'b101, 3'b010, 3'b111, 3'b001, 3'b110, 3'b100};

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  byte_value;
    logic [16:0] match_length;
    logic [11:0] match_offset;
  } token_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    zx7e_pkg::status_t status;
    logic              last;
  } stream_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic cfg_data;

  zx7e_in_if  tok_if ();
  zx7e_out_if res_if ();

  zx7_token_bitstream_encoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tok_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Encoder model state
  logic        word16 = 1'b0;
  logic        hi_first = 1'b0;
  logic        eager_flush = 1'b0;
  logic [15:0] bit_word = '0;
  int unsigned word_fill = 0;
  logic [7:0]  offset_bytes [Q_SLOTS];
  int unsigned obq_wr = 0;
  int unsigned obq_rd = 0;
  logic        byte_dropped;
  stream_res_t token_results [$];
  stream_res_t expected_bytes [$];

  // Stimulus bookkeeping
  token_t pending_tokens [$];
  token_t drv_token;
  int     tokens_queued = 0;
  int     tokens_accepted = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  bit     steady_flow = 1'b0;
  int     fail_count = 0;

  // ------------------------------------------------------------------
  // Encoder model
  // ------------------------------------------------------------------
  function automatic void put_result(logic [7:0] data, zx7e_pkg::status_t st);
    stream_res_t r;
    r = '{out_byte: data, status: st, last: 1'b0};
    if (token_results.size() < RESULT_CAP) token_results.push_back(r);
  endfunction

  function automatic void drain_offsets();
    while (obq_rd != obq_wr) begin
      put_result(offset_bytes[obq_rd], zx7e_pkg::ST_DATA);
      obq_rd = (obq_rd + 1) % Q_SLOTS;
    end
  endfunction

  // Drop the byte when the queue would become full
  function automatic void queue_offset_byte(logic [7:0] data);
    int unsigned nxt;
    nxt = (obq_wr + 1) % Q_SLOTS;
    if (nxt == obq_rd) begin
      byte_dropped = 1'b1;
    end else begin
      offset_bytes[obq_wr] = data;
      obq_wr = nxt;
    end
  endfunction

  function automatic void flush_bit_word();
    if (word16) begin
      if (hi_first) begin
        put_result(bit_word[15:8], zx7e_pkg::ST_DATA);
        put_result(bit_word[7:0], zx7e_pkg::ST_DATA);
      end else begin
        put_result(bit_word[7:0], zx7e_pkg::ST_DATA);
        put_result(bit_word[15:8], zx7e_pkg::ST_DATA);
      end
    end else begin
      put_result(bit_word[7:0], zx7e_pkg::ST_DATA);
    end
    drain_offsets();
    word_fill = 0;
  endfunction

  // A word already at size is flushed before the bit, whatever the flush mode
  function automatic void shift_code_bit(logic b);
    int unsigned word_bits;
    word_bits = word16 ? 16 : 8;
    if (word_fill >= word_bits) flush_bit_word();
    bit_word = {bit_word[14:0], b};
    word_fill++;
    if (eager_flush && word_fill >= word_bits) flush_bit_word();
  endfunction

  function automatic void shift_code(logic [31:0] value, int count);
    for (int i = count - 1; i >= 0; i--) shift_code_bit(value[i]);
  endfunction

  function automatic void encode_token(token_t t);
    int unsigned len;
    int unsigned off;
    int unsigned v;
    int unsigned nb;
    int unsigned word_bits;
    int unsigned off_rest;
    stream_res_t r;
    len = t.match_length;
    off = t.match_offset;
    token_results.delete();
    byte_dropped = 1'b0;
    case (t.action)
      zx7e_pkg::ACT_RAW: begin
        put_result(t.byte_value, zx7e_pkg::ST_DATA);
      end
      zx7e_pkg::ACT_LITERAL: begin
        shift_code_bit(1'b0);
        queue_offset_byte(t.byte_value);
      end
      zx7e_pkg::ACT_MATCH: begin
        if (len < 2 || len > LEN_MAX || off < 1 || off > OFF_MAX) begin
          put_result(8'h00, zx7e_pkg::ST_INVALID);
        end else begin
          // Flag bit, then Elias gamma of length minus one
          v = len - 1;
          nb = 0;
          for (int unsigned s = v; s != 0; s >>= 1) nb++;
          shift_code(32'd1 << (nb - 1), nb);
          shift_code(v, nb);
          if (off <= OFF_SHORT) begin
            queue_offset_byte(8'(off - 1));
          end else begin
            off_rest = off - (OFF_SHORT + 1);
            queue_offset_byte(8'((off_rest & 127) | 128));
            shift_code((off_rest >> 7) & 15, 4);
          end
        end
      end
      default: begin
        // Stop code, pad the open word, drain, then restart the stream
        shift_code(STOP_PATTERN, STOP_LEN);
        word_bits = word16 ? 16 : 8;
        if (word_fill != 0) begin
          while (word_fill < word_bits) begin
            bit_word = {bit_word[14:0], 1'b0};
            word_fill++;
          end
          flush_bit_word();
        end else begin
          drain_offsets();
        end
        bit_word = '0;
        word_fill = 0;
        obq_wr = 0;
        obq_rd = 0;
      end
    endcase
    if (byte_dropped) begin
      while (token_results.size() >= RESULT_CAP) void'(token_results.pop_back());
      put_result(8'h00, zx7e_pkg::ST_OVERFLOW);
    end
    if (token_results.size() > 0) token_results[token_results.size() - 1].last = 1'b1;
    foreach (token_results[i]) begin
      r = token_results[i];
      expected_bytes.push_back(r);
    end
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic token_t mk_token(logic [1:0] act, logic [7:0] data,
                                      logic [16:0] len, logic [11:0] off);
    token_t t;
    t = '{action: act, byte_value: data, match_length: len, match_offset: off};
    return t;
  endfunction

  function automatic token_t random_fields(logic [1:0] act);
    return mk_token(act, 8'($urandom), 17'($urandom), 12'($urandom));
  endfunction

  // Mostly short matches, some long gamma codes, offsets on both encodings
  function automatic token_t random_match(bit well_formed);
    token_t t;
    int unsigned r;
    int unsigned nb;
    int unsigned len;
    t = random_fields(zx7e_pkg::ACT_MATCH);
    r = $urandom_range(0, 99);
    if (well_formed) begin
      if (r < 65) begin
        len = $urandom_range(2, 33);
      end else if (r < 95) begin
        nb = $urandom_range(1, 16);
        len = $urandom_range(1 << (nb - 1), (1 << nb) - 1) + 1;
      end else begin
        len = LEN_MAX;
      end
      t.match_length = 17'(len);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        t.match_offset = 12'($urandom_range(1, OFF_SHORT));
      end else if (r < 90) begin
        t.match_offset = 12'($urandom_range(OFF_SHORT + 1, OFF_MAX));
      end else begin
        case ($urandom_range(0, 3))
          0:       t.match_offset = 12'd1;
          1:       t.match_offset = 12'(OFF_SHORT);
          2:       t.match_offset = 12'(OFF_SHORT + 1);
          default: t.match_offset = 12'(OFF_MAX);
        endcase
      end
    end else begin
      case ($urandom_range(0, 3))
        0: t.match_length = 17'($urandom_range(0, 1));
        1: t.match_length = 17'($urandom_range(LEN_MAX + 1, 131071));
        2: begin
          t.match_length = 17'($urandom_range(2, LEN_MAX));
          t.match_offset = 12'd0;
        end
        default: begin
          t.match_length = 17'($urandom_range(2, LEN_MAX));
          t.match_offset = 12'($urandom_range(OFF_MAX + 1, 4095));
        end
      endcase
    end
    return t;
  endfunction

  task automatic queue_token(token_t t);
    pending_tokens.push_back(t);
    tokens_queued++;
  endtask

  task automatic queue_random_tokens(int n);
    int count;
    int run;
    int unsigned r;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // Literal run: can fill whole words and loads the offset queue
        run = $urandom_range(8, 20);
        repeat (run) queue_token(random_fields(zx7e_pkg::ACT_LITERAL));
        count += run;
      end else begin
        if (r < 40) queue_token(random_fields(zx7e_pkg::ACT_LITERAL));
        else if (r < 74) queue_token(random_match(1'b1));
        else if (r < 81) queue_token(random_match(1'b0));
        else if (r < 89) queue_token(random_fields(zx7e_pkg::ACT_RAW));
        else queue_token(random_fields(zx7e_pkg::ACT_FINISH));
        count++;
      end
    end
  endtask

  // Hold until every item is taken and every expected result is back
  task automatic wait_results_done();
    while (tokens_accepted != tokens_queued) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Also let a token that yields no result finish inside the block
  task automatic wait_idle();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      zx7e_pkg::CFG_WORD_MODE:  word16 = val;
      zx7e_pkg::CFG_BIG_ENDIAN: hi_first = val;
      zx7e_pkg::CFG_FULL_BITS:  eager_flush = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [2:0] setting);
    write_reg(zx7e_pkg::CFG_WORD_MODE, setting[2]);
    write_reg(zx7e_pkg::CFG_BIG_ENDIAN, setting[1]);
    write_reg(zx7e_pkg::CFG_FULL_BITS, setting[0]);
  endtask

  // ------------------------------------------------------------------
  // Clock and run limit
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // ------------------------------------------------------------------
  // Token driver: offer the next pending item, predict on acceptance
  // ------------------------------------------------------------------
  always @(posedge clk) begin : token_driver
    bit offer;
    if (!rst_n) begin
      tok_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = !tok_if.valid;
      if (tok_if.valid && tok_if.ready) begin
        encode_token(drv_token);
        tokens_accepted++;
        offer = 1'b1;
      end
      if (offer) begin
        if (gap_left > 0 || pending_tokens.size() == 0) begin
          tok_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          drv_token = pending_tokens.pop_front();
          tok_if.valid        <= 1'b1;
          tok_if.action       <= drv_token.action;
          tok_if.byte_value   <= drv_token.byte_value;
          tok_if.match_length <= drv_token.match_length;
          tok_if.match_offset <= drv_token.match_offset;
          gap_left = steady_flow ? 0 : idle_gap();
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result monitor: check each accepted item, stall ready at random
  // ------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    stream_res_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("result with nothing expected: out_byte %02h status %0d last %0b",
                 res_if.out_byte, res_if.status, res_if.last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (res_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, res_if.out_byte);
            fail_count++;
          end
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_if.status);
            fail_count++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, res_if.last);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 5) == 0) stall_left = idle_gap();
      end
    end
  end

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------
  initial begin : stimulus
    tok_if.valid        = 1'b0;
    tok_if.action       = zx7e_pkg::ACT_RAW;
    tok_if.byte_value   = '0;
    tok_if.match_length = '0;
    tok_if.match_offset = '0;
    res_if.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = zx7e_pkg::CFG_WORD_MODE;
    cfg_data            = 1'b0;
    rst_n               = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_config(3'b000);

    // Directed: field extremes, both offset encodings, every invalid form
    queue_token(mk_token(zx7e_pkg::ACT_RAW,     8'h00, 17'd0,      12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_RAW,     8'hff, 17'h1ffff,  12'hfff));
    queue_token(mk_token(zx7e_pkg::ACT_LITERAL, 8'h00, 17'd0,      12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_LITERAL, 8'hff, 17'd5,      12'd9));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h11, 17'd2,      12'd1));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h22, 17'd65536,  12'd2176));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h33, 17'd3,      12'd128));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h44, 17'd5,      12'd129));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h55, 17'd0,      12'd10));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h66, 17'd1,      12'd10));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h77, 17'd65537,  12'd10));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h88, 17'h1ffff,  12'hfff));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h99, 17'd10,     12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'haa, 17'd10,     12'd2177));
    queue_token(mk_token(zx7e_pkg::ACT_LITERAL, 8'ha5, 17'd0,      12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_FINISH,  8'h00, 17'd0,      12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_FINISH,  8'hff, 17'h1ffff,  12'hfff));
    queue_token(mk_token(zx7e_pkg::ACT_LITERAL, 8'h5a, 17'd0,      12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_MATCH,   8'h00, 17'd300,    12'd1000));
    queue_token(mk_token(zx7e_pkg::ACT_RAW,     8'h3c, 17'd0,      12'd0));
    queue_token(mk_token(zx7e_pkg::ACT_FINISH,  8'h00, 17'd0,      12'd0));
    repeat (3) queue_token(random_fields(zx7e_pkg::ACT_LITERAL));
    wait_idle();

    // Random phases; the stream stays open across most setting changes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_config(PHASE_CFG[3*ph +: 3]);
      for (int c = 0; c < 2; c++) begin
        steady_flow = (c == 0) && (ph % 3 == 1);
        queue_random_tokens(CHUNK_ITEMS);
        wait_results_done();
      end
      steady_flow = 1'b0;
      if (ph == N_PHASES - 1) queue_token(random_fields(zx7e_pkg::ACT_FINISH));
      else repeat (7) queue_token(random_fields(zx7e_pkg::ACT_LITERAL));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/zx7e_pkg.sv
hdl/zx7e_in_if.sv
hdl/zx7e_out_if.sv
hdl/zx7e_emit.sv
hdl/zx7_token_bitstream_encoder_core.sv
tb/tb_top.sv
